### design/qfe_pkg.sv
// Shared types and constants for the quotient filter engine.
// Holds the item structs, command codes and hash constants; depends on nothing.
package qfe_pkg;

   localparam int QUOTIENT_BITS_DEFAULT  = 10;
   localparam int REMAINDER_BITS_DEFAULT = 8;

   localparam logic [63:0] MIX_MUL_FIRST  = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL_SECOND = 64'hc4ceb9fe1a85ec53;
   localparam int          MIX_SHIFT      = 33;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] key_value;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [10:0] entry_count;
   } rsp_type;

endpackage

### design/quotient_filter_engine.sv
// Quotient filter engine: sequencer, slot memories and response register.
// Depends on qfe_pkg and instantiates qfe_hash.
//
// The engine keeps a quotient filter of 2^QUOTIENT_BITS slots and answers one
// insert, lookup or remove item at a time, each with one result item holding a
// success flag and the live entry count after the command. After reset the
// engine clears its slot memories in a pass over every slot and takes
// no item meanwhile. An item then passes through the hash unit (one shared
// 32x32 multiplier, three partial products per 64-bit multiply), and after that
// every slot the sequencer visits costs a pass through the wait state for the
// single registered read port of the slot memory: walking back to the cluster
// start, counting runs, scanning the run, searching for an empty slot and
// shifting each slot of the cluster one place right. The time per item therefore
// grows with the cluster length: least for an item that lands in an empty slot,
// most for an insert into a crowded cluster.
// A finished result waits in an output register, so the next item is taken
// while the previous result is still stalled.
module quotient_filter_engine #(
   parameter int QUOTIENT_BITS  = qfe_pkg::QUOTIENT_BITS_DEFAULT,
   parameter int REMAINDER_BITS = qfe_pkg::REMAINDER_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qfe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qfe_pkg::rsp_type rsp_data
);
   import qfe_pkg::*;

   localparam int NSLOTS = 1 << QUOTIENT_BITS;
   localparam logic [QUOTIENT_BITS:0] SLOT_COUNT = {1'b1, {QUOTIENT_BITS{1'b0}}};

   typedef enum logic [16:0] {
      ST_CLR  = 17'b00000000000000001,
      ST_IDLE = 17'b00000000000000010,
      ST_HASH = 17'b00000000000000100,
      ST_WAIT = 17'b00000000000001000,
      ST_Q0   = 17'b00000000000010000,
      ST_RA   = 17'b00000000000100000,
      ST_RB   = 17'b00000000001000000,
      ST_RCE  = 17'b00000000010000000,
      ST_RC   = 17'b00000000100000000,
      ST_RSD  = 17'b00000001000000000,
      ST_IS   = 17'b00000010000000000,
      ST_MR   = 17'b00000100000000000,
      ST_SW   = 17'b00001000000000000,
      ST_FIN  = 17'b00010000000000000,
      ST_FIX  = 17'b00100000000000000,
      ST_FL   = 17'b01000000000000000,
      ST_DONE = 17'b10000000000000000
   } state_type;

   typedef struct packed {
      logic [REMAINDER_BITS-1:0] rem;
      logic                      cont;
      logic                      shf;
      logic                      tomb;
   } slot_type;

   // Slot contents move during a shift; occupied marks stay with their quotient.
   slot_type data_mem [NSLOTS];
   logic     occ_mem  [NSLOTS];

   state_type                 state_ff, state_in, ret_ff, ret_in;
   logic [1:0]                cmd_ff, cmd_in;
   logic [QUOTIENT_BITS-1:0]  q_ff, q_in;
   logic [REMAINDER_BITS-1:0] r_ff, r_in;
   logic [QUOTIENT_BITS-1:0]  ptr_ff, ptr_in;
   logic [QUOTIENT_BITS-1:0]  cs_ff, cs_in, rs_ff, rs_in, at_ff, at_in, e_ff, e_in;
   logic [QUOTIENT_BITS-1:0]  clr_ff, clr_in;
   logic [QUOTIENT_BITS:0]    steps_ff, steps_in, n_ff, n_in, live_ff, live_in;
   logic                      was_occ_ff, was_occ_in, first_ff, first_in, ok_ff, ok_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   slot_type                  rd_data_ff;
   logic                      rd_occ_ff;
   logic                      rd_empty;
   logic                      dwe, owe, owdata;
   logic [QUOTIENT_BITS-1:0]  dwaddr, owaddr;
   slot_type                  dwdata;
   logic [QUOTIENT_BITS-1:0]  ptr_nx, ptr_pv;
   logic [63:0]               live_wide;

   logic        hash_start, hash_done;
   logic [63:0] hash_value;

   qfe_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_data.key_value),
      .done  (hash_done),
      .hash  (hash_value)
   );

   assign rd_empty  = !rd_occ_ff && !rd_data_ff.cont && !rd_data_ff.shf;
   assign ptr_nx    = QUOTIENT_BITS'(ptr_ff + 1'b1);
   assign ptr_pv    = QUOTIENT_BITS'(ptr_ff - 1'b1);
   assign live_wide = 64'(live_ff);
   assign req_stall = (state_ff != ST_IDLE);

   // The memory read data is registered from ptr_ff, so every move
   // of the pointer passes through the wait state before the data is used.
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cmd_in       = cmd_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      ptr_in       = ptr_ff;
      cs_in        = cs_ff;
      rs_in        = rs_ff;
      at_in        = at_ff;
      e_in         = e_ff;
      clr_in       = clr_ff;
      steps_in     = steps_ff;
      n_in         = n_ff;
      live_in      = live_ff;
      was_occ_in   = was_occ_ff;
      first_in     = first_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      hash_start   = 1'b0;
      dwe          = 1'b0;
      dwaddr       = ptr_ff;
      dwdata       = rd_data_ff;
      owe          = 1'b0;
      owaddr       = q_ff;
      owdata       = 1'b1;

      unique case (state_ff)
         ST_CLR: begin
            dwe    = 1'b1;
            dwaddr = clr_ff;
            dwdata = '0;
            owe    = 1'b1;
            owaddr = clr_ff;
            owdata = 1'b0;
            clr_in = QUOTIENT_BITS'(clr_ff + 1'b1);
            if (clr_ff == {QUOTIENT_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_data.cmd;
               hash_start = 1'b1;
               state_in   = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               q_in     = hash_value[REMAINDER_BITS +: QUOTIENT_BITS];
               r_in     = hash_value[REMAINDER_BITS-1:0];
               ptr_in   = hash_value[REMAINDER_BITS +: QUOTIENT_BITS];
               ret_in   = ST_Q0;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ret_ff;
         end
         ST_Q0: begin
            ok_in    = 1'b0;
            steps_in = '0;
            state_in = ST_DONE;
            case (cmd_ff) inside
               CMD_INSERT: begin
                  if (live_ff >= SLOT_COUNT) begin
                     state_in = ST_DONE;
                  end else if (rd_empty) begin
                     // The home slot is free: the entry goes straight in.
                     dwe         = 1'b1;
                     dwaddr      = q_ff;
                     dwdata      = '0;
                     dwdata.rem  = r_ff;
                     owe         = 1'b1;
                     live_in     = live_ff + 1'b1;
                     ok_in       = 1'b1;
                  end else begin
                     was_occ_in = rd_occ_ff;
                     state_in   = ST_RA;
                  end
               end
               CMD_LOOKUP, CMD_REMOVE: begin
                  if (rd_occ_ff) begin
                     state_in = ST_RA;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_RA: begin
            // Walk back over shifted slots to the start of the cluster.
            if (steps_ff < SLOT_COUNT && rd_data_ff.shf) begin
               ptr_in   = ptr_pv;
               steps_in = steps_ff + 1'b1;
               ret_in   = ST_RA;
               state_in = ST_WAIT;
            end else begin
               cs_in    = ptr_ff;
               n_in     = '0;
               steps_in = '0;
               state_in = (ptr_ff == q_ff) ? ST_RCE : ST_RB;
            end
         end
         ST_RB: begin
            // Count the occupied quotients between the cluster start and ours.
            n_in     = n_ff + (QUOTIENT_BITS + 1)'(rd_occ_ff);
            ptr_in   = ptr_nx;
            steps_in = steps_ff + 1'b1;
            if (ptr_nx == q_ff || (steps_ff + 1'b1) >= SLOT_COUNT) begin
               state_in = ST_RCE;
            end else begin
               ret_in   = ST_RB;
               state_in = ST_WAIT;
            end
         end
         ST_RCE: begin
            if (n_ff == '0) begin
               rs_in    = cs_ff;
               state_in = ST_RSD;
            end else begin
               ptr_in   = QUOTIENT_BITS'(cs_ff + 1'b1);
               steps_in = '0;
               ret_in   = ST_RC;
               state_in = ST_WAIT;
            end
         end
         ST_RC: begin
            // Skip one run per counted quotient.
            if (rd_data_ff.cont && steps_ff < SLOT_COUNT) begin
               ptr_in   = ptr_nx;
               steps_in = steps_ff + 1'b1;
               ret_in   = ST_RC;
               state_in = ST_WAIT;
            end else begin
               n_in = n_ff - 1'b1;
               if (n_ff == (QUOTIENT_BITS + 1)'(1)) begin
                  rs_in    = ptr_ff;
                  state_in = ST_RSD;
               end else begin
                  ptr_in   = ptr_nx;
                  steps_in = '0;
                  ret_in   = ST_RC;
                  state_in = ST_WAIT;
               end
            end
         end
         ST_RSD: begin
            ptr_in   = rs_ff;
            steps_in = '0;
            first_in = 1'b1;
            at_in    = rs_ff;
            state_in = ST_WAIT;
            if (cmd_ff == CMD_INSERT) begin
               ret_in = was_occ_ff ? ST_IS : ST_MR;
            end else begin
               ret_in = ST_FL;
            end
         end
         ST_IS: begin
            // Find the sorted position of the new remainder within its run.
            if (!first_ff && !rd_data_ff.cont) begin
               at_in    = ptr_ff;
               steps_in = '0;
               state_in = ST_MR;
            end else if (rd_data_ff.rem < r_ff && steps_ff < SLOT_COUNT) begin
               ptr_in   = ptr_nx;
               steps_in = steps_ff + 1'b1;
               first_in = 1'b0;
               ret_in   = ST_IS;
               state_in = ST_WAIT;
            end else begin
               at_in    = ptr_ff;
               steps_in = '0;
               state_in = ST_MR;
            end
         end
         ST_MR: begin
            // Search for a truly empty slot; a full turn means the table is full.
            if (steps_ff >= SLOT_COUNT) begin
               state_in = ST_DONE;
            end else if (!rd_empty) begin
               ptr_in   = ptr_nx;
               steps_in = steps_ff + 1'b1;
               ret_in   = ST_MR;
               state_in = ST_WAIT;
            end else if (ptr_ff == at_ff) begin
               state_in = ST_FIN;
            end else begin
               e_in     = ptr_ff;
               ptr_in   = ptr_pv;
               ret_in   = ST_SW;
               state_in = ST_WAIT;
            end
         end
         ST_SW: begin
            // Move the slot just read one place right; tombstones travel along.
            dwe         = 1'b1;
            dwaddr      = e_ff;
            dwdata.shf  = 1'b1;
            e_in        = ptr_ff;
            if (ptr_ff == at_ff) begin
               state_in = ST_FIN;
            end else begin
               ptr_in   = ptr_pv;
               ret_in   = ST_SW;
               state_in = ST_WAIT;
            end
         end
         ST_FIN: begin
            dwe         = 1'b1;
            dwaddr      = at_ff;
            dwdata.rem  = r_ff;
            dwdata.cont = (at_ff != rs_ff);
            dwdata.shf  = (at_ff != q_ff);
            dwdata.tomb = 1'b0;
            owe         = 1'b1;
            if (at_ff == rs_ff && was_occ_ff) begin
               // The old run head now continues the run behind the new entry.
               ptr_in   = QUOTIENT_BITS'(at_ff + 1'b1);
               ret_in   = ST_FIX;
               state_in = ST_WAIT;
            end else begin
               live_in  = live_ff + 1'b1;
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_FIX: begin
            if (!rd_empty) begin
               dwe         = 1'b1;
               dwdata.cont = 1'b1;
            end
            live_in  = live_ff + 1'b1;
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end
         ST_FL: begin
            // Scan the run for the first live match, skipping tombstones.
            if (!first_ff && !rd_data_ff.cont) begin
               state_in = ST_DONE;
            end else if (steps_ff >= SLOT_COUNT) begin
               state_in = ST_DONE;
            end else if (!rd_data_ff.tomb && rd_data_ff.rem == r_ff) begin
               ok_in    = 1'b1;
               state_in = ST_DONE;
               if (cmd_ff == CMD_REMOVE) begin
                  dwe         = 1'b1;
                  dwdata.tomb = 1'b1;
                  if (live_ff != '0) begin
                     live_in = live_ff - 1'b1;
                  end
               end
            end else if (!rd_data_ff.tomb && rd_data_ff.rem > r_ff) begin
               state_in = ST_DONE;
            end else begin
               ptr_in   = ptr_nx;
               steps_in = steps_ff + 1'b1;
               first_in = 1'b0;
               ret_in   = ST_FL;
               state_in = ST_WAIT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.success     = ok_ff;
               rsp_data_in.entry_count = live_wide[10:0];
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= data_mem[ptr_ff];
      rd_occ_ff  <= occ_mem[ptr_ff];
      if (dwe) begin
         data_mem[dwaddr] <= dwdata;
      end
      if (owe) begin
         occ_mem[owaddr] <= owdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         ret_ff       <= ST_IDLE;
         clr_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      ptr_ff      <= ptr_in;
      cs_ff       <= cs_in;
      rs_ff       <= rs_in;
      at_ff       <= at_in;
      e_ff        <= e_in;
      steps_ff    <= steps_in;
      n_ff        <= n_in;
      was_occ_ff  <= was_occ_in;
      first_ff    <= first_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The live count never exceeds the number of slots.
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= SLOT_COUNT)
      else $error("live count exceeds slot count");

   // A shift step always writes the slot right after the one it just read.
   a_shift_adjacent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SW) |-> (e_ff == ptr_nx))
      else $error("shift writes a slot that is not adjacent");

   // The slot memory is left alone while a key is being hashed.
   a_no_write_hash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HASH) |-> (!dwe && !owe))
      else $error("slot memory written during hashing");

endmodule

### design/qfe_hash.sv
// Iterative 64-bit mix finalizer built around one shared 32x32 multiplier.
// Depends on qfe_pkg for the mix constants.
module qfe_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   output logic        done,
   output logic [63:0] hash
);
   import qfe_pkg::*;

   logic        busy_ff, busy_in;
   logic        round_ff, round_in;
   logic [1:0]  ph_ff, ph_in;
   logic        done_ff, done_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] mul_const;
   logic [31:0] op_a, op_b;
   logic [63:0] sum;

   // Each 64-bit multiply keeps only the low 64 bits of the product, which takes
   // three 32x32 partial products; one phase per partial product plus a final add.
   always_comb begin
      mul_const = round_ff ? MIX_MUL_SECOND : MIX_MUL_FIRST;
      op_a      = (ph_ff == 2'd2) ? x_ff[63:32] : x_ff[31:0];
      op_b      = (ph_ff == 2'd1) ? mul_const[63:32] : mul_const[31:0];
      prod_in   = 64'(op_a) * 64'(op_b);
      sum       = acc_ff + {prod_ff[31:0], 32'd0};
      busy_in   = busy_ff;
      round_in  = round_ff;
      ph_in     = ph_ff;
      done_in   = 1'b0;
      x_in      = x_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         round_in = 1'b0;
         ph_in    = 2'd0;
         x_in     = key ^ (key >> MIX_SHIFT);
      end else if (busy_ff) begin
         ph_in = ph_ff + 2'd1;
         case (ph_ff)
            2'd1: acc_in = prod_ff;
            2'd2: acc_in = sum;
            2'd3: begin
               x_in     = sum ^ (sum >> MIX_SHIFT);
               round_in = 1'b1;
               if (round_ff) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         round_ff <= 1'b0;
         ph_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         round_ff <= round_in;
         ph_ff <= ph_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign hash = x_ff;

endmodule

### tb/quotient_filter_engine_test.sv
// Self-checking testbench for quotient_filter_engine: a bit-exact model of the
// slot table predicts every result item. Depends only on qfe_pkg and the RTL.
module quotient_filter_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import qfe_pkg::*;

   // The package defines the three real commands; code 3 is the unknown one.
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int SLOTS = 1 << QUOTIENT_BITS_DEFAULT;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   quotient_filter_engine uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the filter state, updated as each item is accepted.
   bit [7:0]    slot_rem [SLOTS];
   bit          slot_occ [SLOTS];
   bit          slot_cont[SLOTS];
   bit          slot_shf [SLOTS];
   bit          slot_tomb[SLOTS];
   int unsigned live_entries = 0;

   rsp_type     pending_rsp[$];
   logic [63:0] known_keys[$];
   bit          gaps_on = 1'b1;
   bit          last_refused;
   int          rsp_hold_cycles = 0;
   int          fail_count = 0;
   int          sent_count = 0;
   int          checked_count = 0;
   int          refused_count = 0;

   function automatic logic [63:0] mix_key(logic [63:0] k);
      logic [63:0] h;
      h = k;
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL_FIRST;
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL_SECOND;
      h = h ^ (h >> MIX_SHIFT);
      return h;
   endfunction

   function automatic logic [9:0] quotient_of(logic [63:0] k);
      logic [63:0] h;
      h = mix_key(k);
      return h[17:8];
   endfunction

   function automatic bit slot_free(logic [9:0] s);
      return !slot_occ[s] && !slot_cont[s] && !slot_shf[s];
   endfunction

   // Locate the first slot of the run that belongs to quotient q.
   function automatic logic [9:0] locate_run(logic [9:0] q);
      logic [9:0] cs, s;
      int n, steps;
      cs = q;
      n = 0;
      steps = 0;
      while (slot_shf[cs] && steps < SLOTS) begin
         cs = cs - 10'd1;
         steps++;
      end
      s = cs;
      steps = 0;
      while (s != q && steps < SLOTS) begin
         if (slot_occ[s]) n++;
         s = s + 10'd1;
         steps++;
      end
      s = cs;
      while (n > 0) begin
         s = s + 10'd1;
         steps = 0;
         while (slot_cont[s] && steps < SLOTS) begin
            s = s + 10'd1;
            steps++;
         end
         n--;
      end
      return s;
   endfunction

   // Shift the cluster right from slot at up to the next truly free slot.
   function automatic bit open_slot(logic [9:0] at);
      logic [9:0] e, p;
      int steps;
      e = at;
      steps = 0;
      while (!slot_free(e) && steps < SLOTS) begin
         e = e + 10'd1;
         steps++;
      end
      if (steps >= SLOTS) return 1'b0;
      while (e != at) begin
         p = e - 10'd1;
         slot_rem[e]  = slot_rem[p];
         slot_cont[e] = slot_cont[p];
         slot_tomb[e] = slot_tomb[p];
         slot_shf[e]  = 1'b1;
         e = p;
      end
      slot_rem[at]  = '0;
      slot_cont[at] = 1'b0;
      slot_shf[at]  = 1'b0;
      slot_tomb[at] = 1'b0;
      return 1'b1;
   endfunction

   function automatic bit store_entry(logic [9:0] q, logic [7:0] r);
      bit was_occ;
      logic [9:0] rs, s, t;
      int steps;
      if (live_entries >= SLOTS) return 1'b0;
      if (slot_free(q)) begin
         slot_rem[q]  = r;
         slot_occ[q]  = 1'b1;
         slot_tomb[q] = 1'b0;
         live_entries++;
         return 1'b1;
      end
      was_occ = slot_occ[q];
      slot_occ[q] = 1'b1;
      rs = locate_run(q);
      s = rs;
      if (was_occ) begin
         steps = 0;
         while (slot_rem[s] < r && steps < SLOTS) begin
            s = s + 10'd1;
            steps++;
            if (!slot_cont[s]) break;
         end
      end
      if (!open_slot(s)) begin
         slot_occ[q] = was_occ;
         return 1'b0;
      end
      slot_rem[s] = r;
      if (s != rs) slot_cont[s] = 1'b1;
      if (s != q) slot_shf[s] = 1'b1;
      if (s == rs && was_occ) begin
         t = s + 10'd1;
         if (!slot_free(t)) slot_cont[t] = 1'b1;
      end
      live_entries++;
      return 1'b1;
   endfunction

   // Returns the slot of the first live match, or SLOTS when there is none.
   function automatic int find_entry(logic [9:0] q, logic [7:0] r);
      logic [9:0] s;
      int steps;
      if (!slot_occ[q]) return SLOTS;
      s = locate_run(q);
      steps = 0;
      while (steps < SLOTS) begin
         if (!slot_tomb[s]) begin
            if (slot_rem[s] == r) return int'(s);
            if (slot_rem[s] > r) return SLOTS;
         end
         s = s + 10'd1;
         steps++;
         if (!slot_cont[s]) return SLOTS;
      end
      return SLOTS;
   endfunction

   function automatic rsp_type filter_response(req_type it);
      logic [63:0] h;
      rsp_type res;
      int hit;
      bit ok;
      h = mix_key(it.key_value);
      ok = 1'b0;
      case (it.cmd)
         CMD_INSERT: ok = store_entry(h[17:8], h[7:0]);
         CMD_LOOKUP: ok = find_entry(h[17:8], h[7:0]) < SLOTS;
         CMD_REMOVE: begin
            hit = find_entry(h[17:8], h[7:0]);
            if (hit < SLOTS) begin
               slot_tomb[hit] = 1'b1;
               if (live_entries > 0) live_entries--;
               ok = 1'b1;
            end
         end
         default: ok = 1'b0;
      endcase
      res.success = ok;
      res.entry_count = live_entries[10:0];
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one item; the prediction is made at the edge that accepts it.
   task automatic send_item(logic [1:0] cmd, logic [63:0] key);
      req_type it;
      rsp_type res;
      int gap;
      it.cmd = cmd;
      it.key_value = key;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = filter_response(it);
      pending_rsp.push_back(res);
      last_refused = (cmd == CMD_INSERT) && !res.success;
      if (last_refused) refused_count++;
      if (cmd == CMD_INSERT && res.success) known_keys.push_back(key);
      sent_count++;
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // The receiver stalls at random, sometimes for a long hold, and for a long hold when a test asks.
   always @(negedge clock) begin
      int roll;
      roll = $urandom_range(0, 99);
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else if (!gaps_on || roll < 70) begin
         rsp_stall <= 1'b0;
      end else if (roll < 97) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles <= $urandom_range(10, 40);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result item with no expectation waiting");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.success !== want.success) begin
               $error("success: expected %0d, got %0d", want.success, rsp_data.success);
               fail_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_data.entry_count);
               fail_count++;
            end
            checked_count++;
         end
      end
   end

   // Commands on an empty filter, the unknown command and extreme keys.
   task automatic test_basic_commands();
      send_item(CMD_UNKNOWN, '0);
      send_item(CMD_LOOKUP, 64'h0);
      send_item(CMD_REMOVE, 64'h0);
      send_item(CMD_INSERT, 64'h0);
      send_item(CMD_INSERT, '1);
      send_item(CMD_LOOKUP, 64'h0);
      send_item(CMD_LOOKUP, '1);
      send_item(CMD_INSERT, 64'h0);
      send_item(CMD_REMOVE, 64'h0);
      send_item(CMD_LOOKUP, 64'h0);
      send_item(CMD_REMOVE, 64'h0);
      send_item(CMD_REMOVE, 64'h0);
      send_item(CMD_LOOKUP, 64'h0);
      send_item(CMD_UNKNOWN, '1);
      send_item(CMD_REMOVE, '1);
   endtask

   // Several keys with one quotient build a run that must stay sorted.
   task automatic test_shared_quotient();
      logic [63:0] base, k;
      logic [63:0] mates[$];
      base = {$urandom, $urandom};
      k = base;
      while (mates.size() < 4) begin
         k = k + 64'd1;
         if (quotient_of(k) == quotient_of(base)) mates.push_back(k);
      end
      send_item(CMD_INSERT, base);
      foreach (mates[i]) send_item(CMD_INSERT, mates[i]);
      send_item(CMD_LOOKUP, mates[2]);
      send_item(CMD_REMOVE, mates[1]);
      send_item(CMD_LOOKUP, mates[1]);
      send_item(CMD_LOOKUP, mates[3]);
      send_item(CMD_INSERT, mates[1]);
      send_item(CMD_LOOKUP, mates[1]);
   endtask

   // The receiver holds off long enough for the engine to stall its input.
   task automatic test_backpressure();
      rsp_hold_cycles = 400;
      repeat (20) send_item(CMD_INSERT, {$urandom, $urandom});
   endtask

   function automatic logic [63:0] choose_key();
      if (known_keys.size() > 0 && $urandom_range(0, 99) < 75)
         return known_keys[$urandom_range(0, known_keys.size() - 1)];
      return {$urandom, $urandom};
   endfunction

   // Mixed traffic; most lookups and removes target keys already inserted.
   task automatic test_random_mix(int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) gaps_on = 1'b0;
         if (i == count / 2 + 150) gaps_on = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 30) send_item(CMD_INSERT, choose_key());
         else if (roll < 75) send_item(CMD_LOOKUP, choose_key());
         else if (roll < 95) send_item(CMD_REMOVE, choose_key());
         else send_item(CMD_UNKNOWN, {$urandom, $urandom});
      end
   endtask

   // Fill every slot; tombstones then leave no truly empty slot to shift into.
   task automatic test_saturation();
      int tries;
      tries = 0;
      last_refused = 1'b0;
      while (!last_refused && tries < 1200) begin
         send_item(CMD_INSERT, {$urandom, $urandom});
         tries++;
      end
      send_item(CMD_INSERT, {$urandom, $urandom});
      send_item(CMD_LOOKUP, choose_key());
      send_item(CMD_UNKNOWN, {$urandom, $urandom});
   endtask

   initial begin
      #40ms;
      $display("** quotient_filter_engine: FAILED **");
      $finish;
   end

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_commands();
      test_shared_quotient();
      test_backpressure();
      test_random_mix(1150);
      test_saturation();
      idle_sender();
      waited = 0;
      while (pending_rsp.size() > 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (pending_rsp.size() > 0) begin
         $error("%0d expected results never arrived", pending_rsp.size());
         fail_count++;
      end
      $display("Sent %0d items, checked %0d results, %0d inserts refused.",
               sent_count, checked_count, refused_count);
      $display("Covered empty, shared-quotient, stalled, random and saturated tables.");
      if (fail_count == 0) begin
         $display("** quotient_filter_engine: PASSED **");
      end else begin
         $display("** quotient_filter_engine: FAILED **");
      end
      $finish;
   end

endmodule
